// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that cond implies prop in the same cycle.
`define ASSERT_IMPL(label, cond, prop, msg) \
	`ASSERT_CLK(label, (cond) |-> (prop), msg)

`endif

// File: src/b64wd_pkg.sv
// ----------------------------------------------------------------------------
// b64wd_pkg
// Types, codes and the character classifier of the base64 word decoder.
// ----------------------------------------------------------------------------
package b64wd_pkg;

	localparam logic [15:0] LIMIT_RESET = 16'hFFFF;

	localparam logic [6:0] CLS_PAD  = 7'd64;
	localparam logic [6:0] CLS_SKIP = 7'd65;
	localparam logic [6:0] CLS_ERR  = 7'd66;

	localparam logic KIND_DATA   = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] ST_NONE = 2'd0;
	localparam logic [1:0] ST_OK   = 2'd1;
	localparam logic [1:0] ST_ERR  = 2'd2;

	typedef struct packed {
		logic [7:0] in_char;
		logic       end_of_text;
	} char_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] data_byte;
		logic [1:0] status;
		logic       last_result;
	} result_item_t;

	typedef struct packed {
		logic [2:0][5:0] store;
		logic [1:0]      cnt;
		logic [15:0]     bytes_written;
		logic            decoded_any;
		logic            halted;
		logic            input_error;
	} dec_state_t;

	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      nbytes;
		logic            has_status;
		logic [1:0]      status;
		logic [2:0]      total;
	} result_set_t;

	function automatic logic [6:0] classify(input logic [7:0] c);
		logic [6:0] v;
		if (c >= 8'h41 && c <= 8'h5A)
			v = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A)
			v = 7'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			v = 7'(c - 8'h30 + 8'd52);
		else if (c == 8'h2B)
			v = 7'd62;
		else if (c == 8'h2F)
			v = 7'd63;
		else if (c == 8'h3D || c == 8'h3F)
			v = CLS_PAD;
		else if ((c >= 8'd8 && c <= 8'd11) || c == 8'd13 || c == 8'd32)
			v = CLS_SKIP;
		else
			v = CLS_ERR;
		return v;
	endfunction

endpackage

// File: src/base64_word_decoder_unit.sv
// ----------------------------------------------------------------------------
// base64_word_decoder_unit
// Base64 decoder for MIME encoded words, one character per request.
// ----------------------------------------------------------------------------
//  channel  | direction | payload        | handshake
//  ---------+-----------+----------------+-------------------------
//  char     | in        | char_item_t    | char_valid / char_ready
//  result   | out       | result_item_t  | result_valid / result_ready
//  cfg      | in        | output_limit   | cfg_valid / cfg_ready
//
// A character enters the input register and is decoded there combinationally;
// its results (up to three bytes and a status) load a result set that drains
// one result per cycle while result_ready is high. A character with no result
// leaves the register in the next cycle; one with results waits until the set
// is empty or its last result is taken.
// Reset clears all decoder state and sets output_limit to 65535.
// ----------------------------------------------------------------------------
module base64_word_decoder_unit
	import b64wd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         char_valid,
	output logic         char_ready,
	input  char_item_t   char_item,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result_item,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	logic [15:0] limit_q;
	logic        valid_s1;
	char_item_t  item_s1;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	result_set_t rs;
	result_set_t set_q;
	logic        set_valid_q;
	logic [1:0]  ptr_q;
	logic        pop;
	logic        pop_last;
	logic        set_free;
	logic        adv_s1;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	b64wd_decode u_decode (
		.item  (item_s1),
		.cur   (state_q),
		.limit (limit_q),
		.nxt   (state_nxt),
		.rs    (rs)
	);

	assign pop      = set_valid_q && result_ready;
	assign pop_last = pop && ({1'b0, ptr_q} + 3'd1 == set_q.total);
	assign set_free = !set_valid_q || pop_last;
	assign adv_s1   = valid_s1 && (rs.total == 3'd0 || set_free);
	assign char_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_ready && char_valid)
			item_s1 <= char_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_valid_q <= 1'b0;
			ptr_q <= 2'd0;
		end else if (adv_s1 && rs.total != 3'd0) begin
			set_valid_q <= 1'b1;
			ptr_q <= 2'd0;
		end else if (pop_last) begin
			set_valid_q <= 1'b0;
		end else if (pop) begin
			ptr_q <= ptr_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && rs.total != 3'd0)
			set_q <= rs;
	end

	always_comb begin
		result_valid = set_valid_q;
		result_item.last_result = ({1'b0, ptr_q} + 3'd1 == set_q.total);
		if (ptr_q < set_q.nbytes) begin
			result_item.result_kind = KIND_DATA;
			result_item.data_byte = set_q.bytes[ptr_q];
			result_item.status = ST_NONE;
		end else begin
			result_item.result_kind = KIND_STATUS;
			result_item.data_byte = 8'd0;
			result_item.status = set_q.status;
		end
	end

endmodule

// File: src/b64wd_decode.sv
// ----------------------------------------------------------------------------
// b64wd_decode
// Next-state and result-set logic for one character of base64 text.
// ----------------------------------------------------------------------------
module b64wd_decode
	import b64wd_pkg::*;
(
	input  char_item_t  item,
	input  dec_state_t  cur,
	input  logic [15:0] limit,
	output dec_state_t  nxt,
	output result_set_t rs
);

	logic [6:0]      v;
	logic [2:0][5:0] m;
	logic [5:0]      s3;
	logic [2:0][7:0] b;
	logic [15:0]     bw_inc;
	logic [16:0]     bw_next_end;

	always_comb begin
		v = classify(item.in_char);
		for (int k = 0; k < 3; k++)
			m[k] = (2'(k) < cur.cnt) ? cur.store[k] : 6'd0;
		s3 = v[6] ? 6'd0 : v[5:0];
		b[0] = {m[0], m[1][5:4]};
		b[1] = {m[1][3:0], m[2][5:2]};
		b[2] = {m[2][1:0], s3};
		bw_inc = cur.bytes_written + 16'd3;
		bw_next_end = {1'b0, bw_inc} + 17'd3;
	end

	always_comb begin
		nxt = cur;
		rs = '0;
		rs.bytes = b;
		if (!cur.halted && limit != 16'd0) begin
			priority if (v == CLS_ERR) begin
				nxt.halted = 1'b1;
				nxt.input_error = 1'b1;
			end else if (v == CLS_SKIP) begin
				nxt = cur;
			end else if (v == CLS_PAD) begin
				rs.nbytes = (cur.cnt >= 2'd2) ? cur.cnt - 2'd1 : 2'd0;
				nxt.decoded_any = 1'b1;
				nxt.cnt = 2'd0;
				nxt.halted = 1'b1;
			end else if (cur.cnt != 2'd3) begin
				for (int k = 0; k < 3; k++)
					if (2'(k) == cur.cnt)
						nxt.store[k] = v[5:0];
				nxt.cnt = cur.cnt + 2'd1;
			end else begin
				rs.nbytes = 2'd3;
				nxt.decoded_any = 1'b1;
				nxt.cnt = 2'd0;
				nxt.bytes_written = bw_inc;
				if (bw_next_end > {1'b0, limit})
					nxt.halted = 1'b1;
			end
		end
		if (item.end_of_text) begin
			rs.has_status = 1'b1;
			if (limit == 16'd0 || nxt.input_error || nxt.cnt != 2'd0)
				rs.status = ST_ERR;
			else
				rs.status = nxt.decoded_any ? ST_OK : ST_NONE;
			nxt = '0;
		end
		rs.total = {1'b0, rs.nbytes} + {2'b0, rs.has_status};
	end

endmodule

// File: src/b64wd_checker.sv
// ----------------------------------------------------------------------------
// b64wd_checker
// Port-level checks of the base64 word decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module b64wd_checker
	import b64wd_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	input logic         result_valid,
	input logic         result_ready,
	input result_item_t result_item
);

	`ASSERT_CLK(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result_item), "result request dropped or changed while stalled")
	`ASSERT_IMPL(a_status_last, result_valid && result_item.result_kind == KIND_STATUS, result_item.data_byte == 8'd0 && result_item.last_result, "status result not last or carries data")
	`ASSERT_IMPL(a_data_status, result_valid && result_item.result_kind == KIND_DATA, result_item.status == ST_NONE, "data result carries a status")
	`ASSERT_IMPL(a_status_code, result_valid, result_item.status == ST_NONE || result_item.status == ST_OK || result_item.status == ST_ERR, "undefined status code")

endmodule

bind base64_word_decoder_unit b64wd_checker u_b64wd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result_item  (result_item)
);

// File: verif/base64_word_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// base64_word_decoder_unit_tb
// Self-checking bench for the base64 word decoder. It sends text one
// character per request under several output limits: a directed set, then
// random texts, most of them well formed, some broken, some noise. A
// scoreboard predicts every data byte and status. Random gaps fall on both
// channels, with two long receiver hold-offs and pauses that drain all results.
// ----------------------------------------------------------------------------
module base64_word_decoder_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import b64wd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 80;
	localparam int SETTLE_CYCLES = 8;

	typedef enum logic [1:0] {CH_SEXTET, CH_PAD, CH_SPACE, CH_BAD} char_class_t;

	class dec_scoreboard;
		logic [15:0]  output_limit;
		logic [5:0]   sextets [3];
		logic [1:0]   count;
		logic [15:0]  written;
		bit           decoded_any;
		bit           halted;
		bit           input_error;
		result_item_t expected_q [$];
		int           errors;

		function new();
			output_limit = LIMIT_RESET;
			errors = 0;
			clear_text();
		endfunction

		function void clear_text();
			foreach (sextets[k])
				sextets[k] = '0;
			count = '0;
			written = '0;
			decoded_any = 0;
			halted = 0;
			input_error = 0;
		endfunction

		function char_class_t classify_char(input logic [7:0] c, output logic [5:0] v);
			v = '0;
			if (c >= "A" && c <= "Z") begin
				v = 6'(c - "A");
				return CH_SEXTET;
			end
			if (c >= "a" && c <= "z") begin
				v = 6'(c - "a" + 8'd26);
				return CH_SEXTET;
			end
			if (c >= "0" && c <= "9") begin
				v = 6'(c - "0" + 8'd52);
				return CH_SEXTET;
			end
			if (c == "+") begin
				v = 6'd62;
				return CH_SEXTET;
			end
			if (c == "/") begin
				v = 6'd63;
				return CH_SEXTET;
			end
			if (c == "=" || c == "?")
				return CH_PAD;
			if ((c >= 8'd8 && c <= 8'd11) || c == 8'd13 || c == 8'd32)
				return CH_SPACE;
			return CH_BAD;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_char(input char_item_t it);
			result_item_t batch [4];
			logic [7:0]   bytes [3];
			logic [5:0]   v;
			char_class_t  cls;
			int           n;
			int           nbytes;
			bit           active;
			logic [1:0]   st;
			n = 0;
			nbytes = 0;
			active = !halted && output_limit != 16'd0;
			if (active) begin
				cls = classify_char(it.in_char, v);
				case (cls)
					CH_BAD: begin
						halted = 1;
						input_error = 1;
					end
					CH_PAD: begin
						for (int k = count; k < 3; k++)
							sextets[k] = '0;
						nbytes = (count >= 2) ? count - 1 : 0;
						v = '0;
						decoded_any = 1;
						count = '0;
						halted = 1;
					end
					CH_SEXTET: begin
						if (count < 2'd3) begin
							sextets[count] = v;
							count = count + 2'd1;
						end else begin
							nbytes = 3;
							decoded_any = 1;
							count = '0;
							written = written + 16'd3;
							if ({1'b0, written} + 17'd3 > {1'b0, output_limit})
								halted = 1;
						end
					end
					default: ;
				endcase
				bytes[0] = {sextets[0], sextets[1][5:4]};
				bytes[1] = {sextets[1][3:0], sextets[2][5:2]};
				bytes[2] = {sextets[2][1:0], v};
				for (int k = 0; k < nbytes; k++) begin
					batch[n] = result_item_t'{KIND_DATA, bytes[k], ST_NONE, 1'b0};
					n++;
				end
			end
			if (it.end_of_text) begin
				if (output_limit == 16'd0 || input_error || count != 2'd0)
					st = ST_ERR;
				else
					st = decoded_any ? ST_OK : ST_NONE;
				batch[n] = result_item_t'{KIND_STATUS, 8'd0, st, 1'b0};
				n++;
				clear_text();
			end
			if (n > 0)
				batch[n - 1].last_result = 1'b1;
			for (int k = 0; k < n; k++)
				expected_q.push_back(batch[k]);
		endfunction

		task mismatch_report(input string msg);
			errors++;
			$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		task check_result(input result_item_t r);
			result_item_t want;
			if (expected_q.size() == 0) begin
				mismatch_report($sformatf("unexpected result %h", r));
				return;
			end
			want = expected_q.pop_front();
			if (r.result_kind !== want.result_kind)
				mismatch_report($sformatf("result_kind got %b expected %b",
					r.result_kind, want.result_kind));
			if (r.data_byte !== want.data_byte)
				mismatch_report($sformatf("data_byte got %h expected %h",
					r.data_byte, want.data_byte));
			if (r.status !== want.status)
				mismatch_report($sformatf("status got %0d expected %0d",
					r.status, want.status));
			if (r.last_result !== want.last_result)
				mismatch_report($sformatf("last_result got %b expected %b",
					r.last_result, want.last_result));
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         char_valid;
	logic         char_ready;
	char_item_t   char_item;
	logic         result_valid;
	logic         result_ready;
	result_item_t result_item;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [15:0]  cfg_data;

	dec_scoreboard sb = new();
	logic [7:0]    text_q [$];
	int            used_items;
	int            burst_left;
	int            hold_seq;
	bit            valid_on;

	base64_word_decoder_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_valid   (char_valid),
		.char_ready   (char_ready),
		.char_item    (char_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function void add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_q.push_back(s[i]);
	endfunction

	function logic [7:0] sextet_char(input logic [5:0] s);
		if (s < 6'd26)
			return 8'h41 + 8'(s);
		if (s < 6'd52)
			return 8'h61 + 8'(s - 6'd26);
		if (s < 6'd62)
			return 8'h30 + 8'(s - 6'd52);
		return (s == 6'd62) ? "+" : "/";
	endfunction

	function logic [7:0] space_char();
		case ($urandom_range(0, 5))
			0: return 8'd8;
			1: return 8'd9;
			2: return 8'd10;
			3: return 8'd11;
			4: return 8'd13;
			default: return 8'd32;
		endcase
	endfunction

	function void add_sym();
		if ($urandom_range(0, 7) == 0)
			text_q.push_back(space_char());
		text_q.push_back(sextet_char(6'($urandom_range(0, 63))));
	endfunction

	function void add_pad();
		text_q.push_back($urandom_range(0, 1) ? "=" : "?");
	endfunction

	task automatic lower_valid();
		if (valid_on) begin
			char_valid <= 1'b0;
			valid_on = 0;
		end
	endtask

	task automatic drain();
		lower_valid();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_text();
		char_item_t it;
		int gap;
		for (int i = 0; i < text_q.size(); i++) begin
			it.in_char = text_q[i];
			it.end_of_text = (i == text_q.size() - 1);
			char_item <= it;
			char_valid <= 1'b1;
			valid_on = 1;
			do @(posedge clk); while (!char_ready);
			sb.note_char(it);
			used_items++;
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				gap = $urandom_range(1, 6);
				burst_left = $urandom_range(0, 12);
				lower_valid();
				repeat (gap) @(posedge clk);
			end
		end
		text_q.delete();
	endtask

	task automatic write_limit(input logic [15:0] value);
		drain();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.output_limit = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic gen_text();
		int mode;
		int n;
		mode = $urandom_range(0, 9);
		if (mode <= 5) begin
			repeat ($urandom_range(0, 3) * 4) add_sym();
			case ($urandom_range(0, 3))
				2: begin
					repeat (2) add_sym();
					add_pad();
					if ($urandom_range(0, 1))
						add_pad();
				end
				3: begin
					repeat (3) add_sym();
					add_pad();
				end
				default: if ($urandom_range(0, 2) == 0)
					add_pad();
			endcase
		end else if (mode <= 7) begin
			n = $urandom_range(1, 9);
			repeat (n) add_sym();
			if ($urandom_range(0, 1)) begin
				add_pad();
				repeat ($urandom_range(0, 3)) add_sym();
			end
		end else if (mode == 8) begin
			repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat (4) add_sym();
			text_q.push_back(8'($urandom_range(0, 255)));
			repeat (2) add_sym();
		end
		if (text_q.size() == 0)
			text_q.push_back(space_char());
	endtask

	task automatic run_phase(input int target);
		used_items = 0;
		while (used_items < target) begin
			gen_text();
			send_text();
			if ($urandom_range(0, 24) == 0)
				drain();
		end
	endtask

	// result side: own stall pattern plus a long hold-off on request
	initial begin
		int hold_left;
		int stall_left;
		int run_left;
		int seen_hold;
		hold_left = 0;
		stall_left = 0;
		run_left = 0;
		seen_hold = 0;
		result_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (result_valid && result_ready)
					sb.check_result(result_item);
				if (hold_seq != seen_hold) begin
					seen_hold = hold_seq;
					hold_left = HOLD_CYCLES;
				end
				if (hold_left > 0) begin
					hold_left--;
					result_ready <= 1'b0;
				end else if (stall_left > 0) begin
					stall_left--;
					result_ready <= 1'b0;
				end else if (run_left > 0) begin
					run_left--;
					result_ready <= 1'b1;
				end else begin
					run_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 10);
					stall_left = $urandom_range(1, 5);
					result_ready <= 1'b1;
				end
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("base64_word_decoder_unit test failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_item = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		valid_on = 0;
		used_items = 0;
		burst_left = 0;
		hold_seq = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_str("TWFu");
		send_text();
		add_str("TQ==");
		send_text();
		text_q.push_back(8'd8);
		add_str("TWE?");
		send_text();
		add_str("=");
		send_text();
		add_str("A=");
		send_text();
		add_str("+/az09Z");
		send_text();
		text_q.push_back(8'hFF);
		send_text();
		text_q.push_back(8'h00);
		add_str("A");
		send_text();
		text_q.push_back(8'd13);
		text_q.push_back(8'd32);
		send_text();
		drain();

		hold_seq <= hold_seq + 1;
		burst_left = 60;
		run_phase(15);
		write_limit(16'd0);
		run_phase(5);
		write_limit(16'd1);
		run_phase(6);
		write_limit(16'd2);
		run_phase(6);
		write_limit(16'd6);
		run_phase(8);
		write_limit(16'($urandom_range(3, 40)));
		run_phase(10);
		write_limit(16'hFFFF);
		hold_seq <= hold_seq + 1;
		burst_left = 60;
		run_phase(10);

		drain();
		repeat (20) @(posedge clk);
		if (sb.pending() != 0)
			sb.mismatch_report($sformatf("%0d results never arrived", sb.pending()));
		if (sb.errors == 0)
			$display("base64_word_decoder_unit test passed");
		else
			$display("base64_word_decoder_unit test failed");
		$finish;
	end

endmodule
